### hw/rtl/adt_pkg.sv
// Package for the difficulty target pipeline: widths, constants, stage types
// and the compact encode/decode and division step functions. No dependencies.
`default_nettype none
package adt_pkg;

    localparam int NUM_W     = 62;
    localparam int DIV_STEPS = NUM_W;
    localparam int TGT_W     = 256;
    localparam int LANES     = 8;

    localparam logic [63:0] POLY_C1   = 64'd195766423245049;
    localparam logic [63:0] POLY_C2   = 64'd971821376;
    localparam logic [63:0] POLY_C3   = 64'd5127;
    localparam logic [63:0] POLY_HALF = 64'd1 << 47;
    localparam logic [16:0] ONE_FIX   = 17'd65536;

    localparam logic [2:0] REG_ACT_HEIGHT = 3'd0;
    localparam logic [2:0] REG_REF_BITS   = 3'd1;
    localparam logic [2:0] REG_REF_TIME   = 3'd2;
    localparam logic [2:0] REG_SPACING    = 3'd3;
    localparam logic [2:0] REG_HALF_LIFE  = 3'd4;
    localparam logic [2:0] REG_LIMIT_BITS = 3'd5;

    typedef struct packed {
        logic        valid;
        logic        applied;
        logic [31:0] bits;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic              neg;
        logic [31:0]       hl;
        logic [31:0]       rem;
        logic [NUM_W-1:0]  num;
    } div_t;

    typedef struct packed {
        side_t              side;
        logic signed [62:0] expo;
    } exp_t;

    typedef struct packed {
        side_t              side;
        logic [16:0]        factor;
        logic signed [47:0] shifts;
    } fac_t;

    function automatic div_t div_step(input div_t d);
        div_t        r;
        logic [32:0] t;
        r = d;
        t = {d.rem, d.num[NUM_W-1]};
        if (t >= {1'b0, d.hl})
        begin
            r.rem = 32'(t - {1'b0, d.hl});
            r.num = {d.num[NUM_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[31:0];
            r.num = {d.num[NUM_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [TGT_W-1:0] decode_compact(input logic [31:0] bits);
        logic [7:0]       size;
        logic [22:0]      word;
        logic [TGT_W-1:0] r;
        size = bits[31:24];
        word = bits[22:0];
        if (size <= 8'd3)
        begin
            r = {233'b0, word >> (5'(8 * (3 - size[1:0])))};
        end
        else
        begin
            r = {233'b0, word} << ({3'b0, 8'(size - 8'd3)} << 3);
        end
        return r;
    endfunction

    function automatic logic [31:0] encode_compact(input logic [TGT_W-1:0] a);
        logic [8:0]       nbits;
        logic [8:0]       size;
        logic [31:0]      compact;
        logic [TGT_W-1:0] t;
        nbits = 9'd0;
        for (int i = 0; i < TGT_W; i++)
        begin
            if (a[i])
            begin
                nbits = 9'(i + 1);
            end
        end
        size = (nbits + 9'd7) >> 3;
        if (size <= 9'd3)
        begin
            compact = a[31:0] << (5'(8 * (3 - size[1:0])));
        end
        else
        begin
            t = a >> ({3'b0, size - 9'd3} << 3);
            compact = t[31:0];
        end
        if (compact[23])
        begin
            compact = compact >> 8;
            size = size + 9'd1;
        end
        return {size[7:0], compact[23:0]};
    endfunction

endpackage
`default_nettype wire

### hw/rtl/adt_divider.sv
// Restoring divider, one quotient bit per pipeline stage, giving the signed
// 47.16 exponent truncated toward zero. Depends on adt_pkg.
`default_nettype none
module adt_divider (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire adt_pkg::div_t din,
    output adt_pkg::exp_t      dout
);
    import adt_pkg::*;

    div_t st_reg [DIV_STEPS];
    exp_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                st_reg[k].side.valid <= 1'b0;
            end
            out_reg.side.valid <= 1'b0;
        end
        else if (adv)
        begin
            st_reg[0] <= div_step(din);
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                st_reg[k] <= div_step(st_reg[k-1]);
            end
            out_reg.side <= st_reg[DIV_STEPS-1].side;
            out_reg.expo <= st_reg[DIV_STEPS-1].neg
                          ? -$signed({1'b0, st_reg[DIV_STEPS-1].num})
                          :  $signed({1'b0, st_reg[DIV_STEPS-1].num});
        end
    end

    assign dout = out_reg;

endmodule
`default_nettype wire

### hw/rtl/adt_poly.sv
// Cubic approximation of 2^frac as a 1.16 factor over four stages, plus the
// integer shift count. Depends on adt_pkg.
`default_nettype none
module adt_poly (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire adt_pkg::exp_t din,
    output adt_pkg::fac_t      dout
);
    import adt_pkg::*;

    side_t              s1_reg, s2_reg, s3_reg;
    logic signed [47:0] sh1_reg, sh2_reg, sh3_reg;
    logic [15:0]        frac1_reg;
    logic [63:0]        a1_reg, a2_reg, a3_reg;
    logic [31:0]        f2_reg;
    logic [63:0]        b2_reg, b3_reg;
    logic [47:0]        f3_reg;
    logic [63:0]        c3_reg;
    fac_t               out_reg;
    logic signed [46:0] sh_int;
    logic [63:0]        poly;

    assign sh_int = din.expo[62:16];
    assign poly   = a3_reg + b3_reg + c3_reg + POLY_HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg.valid  <= 1'b0;
            s2_reg.valid  <= 1'b0;
            s3_reg.valid  <= 1'b0;
            out_reg.side.valid <= 1'b0;
        end
        else if (adv)
        begin
            s1_reg    <= din.side;
            sh1_reg   <= {sh_int[46], sh_int} - 48'sd16;
            frac1_reg <= din.expo[15:0];
            a1_reg    <= POLY_C1 * {48'b0, din.expo[15:0]};
            f2_reg    <= {16'b0, din.expo[15:0]} * {16'b0, din.expo[15:0]};

            s2_reg  <= s1_reg;
            sh2_reg <= sh1_reg;
            a2_reg  <= a1_reg;
            b2_reg  <= POLY_C2 * {32'b0, f2_reg};
            f3_reg  <= {16'b0, f2_reg} * {32'b0, frac1_reg};

            s3_reg  <= s2_reg;
            sh3_reg <= sh2_reg;
            a3_reg  <= a2_reg;
            b3_reg  <= b2_reg;
            c3_reg  <= POLY_C3 * {16'b0, f3_reg};

            out_reg.side   <= s3_reg;
            out_reg.shifts <= sh3_reg;
            out_reg.factor <= ONE_FIX + {1'b0, poly[63:48]};
        end
    end

    assign dout = out_reg;

endmodule
`default_nettype wire

### hw/rtl/adt_target.sv
// Scales the 256-bit anchor target by the factor, shifts, clamps and encodes
// it in compact form over six stages (keeping the input bits when not applied). Depends on adt_pkg.
`default_nettype none
module adt_target (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire adt_pkg::fac_t             din,
    input  wire logic [adt_pkg::TGT_W-1:0] anchor_target,
    input  wire logic [adt_pkg::TGT_W-1:0] limit,
    output adt_pkg::side_t                 dout
);
    import adt_pkg::*;

    side_t              s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, out_reg;
    logic signed [47:0] sh1_reg, sh2_reg;
    logic [48:0]        lane_reg [LANES];
    logic [TGT_W-1:0]   prod_reg, shf_reg, clmp_reg;
    logic [TGT_W-1:0]   prod_next, shf_next;
    logic [TGT_W-1:0]   even_sum, odd_sum;
    logic [47:0]        amt;
    logic [8:0]         back_amt;
    logic               ovf;

    // Even lanes never overlap one another, nor do odd lanes, so each set is merged
    // without carries and a single addition forms the product.
    always_comb
    begin
        even_sum = '0;
        odd_sum  = '0;
        for (int i = 0; i < LANES; i += 2)
        begin
            even_sum = even_sum | ({207'b0, lane_reg[i]} << (32 * i));
            odd_sum  = odd_sum | ({207'b0, lane_reg[i+1]} << (32 * (i + 1)));
        end
        prod_next = even_sum + odd_sum;
    end

    always_comb
    begin
        amt      = 48'(-sh2_reg);
        back_amt = 9'd256 - {1'b0, sh2_reg[7:0]};
        ovf      = 1'b0;
        shf_next = '0;
        if (sh2_reg[47] || sh2_reg == 48'sd0)
        begin
            if (amt[47:8] == 40'd0)
            begin
                shf_next = prod_reg >> amt[7:0];
            end
        end
        else if (sh2_reg[46:8] != 39'd0)
        begin
            ovf = prod_reg != '0;
        end
        else
        begin
            ovf      = (prod_reg >> back_amt) != '0;
            shf_next = prod_reg << sh2_reg[7:0];
        end
        if (ovf)
        begin
            shf_next = limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg.valid  <= 1'b0;
            s2_reg.valid  <= 1'b0;
            s3_reg.valid  <= 1'b0;
            s4_reg.valid  <= 1'b0;
            s5_reg.valid  <= 1'b0;
            out_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            s1_reg  <= din.side;
            sh1_reg <= din.shifts;
            for (int i = 0; i < LANES; i++)
            begin
                lane_reg[i] <= {17'b0, anchor_target[32*i +: 32]} * {32'b0, din.factor};
            end

            s2_reg   <= s1_reg;
            sh2_reg  <= sh1_reg;
            prod_reg <= prod_next;

            s3_reg  <= s2_reg;
            shf_reg <= shf_next;

            s4_reg <= s3_reg;
            if (shf_reg == '0)
            begin
                clmp_reg <= {{(TGT_W-1){1'b0}}, 1'b1};
            end
            else if (shf_reg > limit)
            begin
                clmp_reg <= limit;
            end
            else
            begin
                clmp_reg <= shf_reg;
            end

            s5_reg.valid   <= s4_reg.valid;
            s5_reg.applied <= s4_reg.applied;
            s5_reg.bits    <= s4_reg.applied ? encode_compact(clmp_reg) : s4_reg.bits;

            out_reg <= s5_reg;
        end
    end

    assign dout = out_reg;

endmodule
`default_nettype wire

### hw/rtl/asert_difficulty_target.sv
// ASERT difficulty target: one header item in, one compact target item out,
// and a new item may enter every cycle while the output is not stalled.
// Each item passes the input register, the 62-stage one-bit-per-stage divider
// by the half-life, the polynomial, scaling, shift, clamp and encode stages
// and the output register. A stall on a valid output halts the whole pipeline.
// Configuration is decoded in the cycle after a write.
// Depends on adt_pkg, adt_divider, adt_poly and adt_target.
`default_nettype none
module asert_difficulty_target (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] prev_bits,
    input  wire logic [31:0] prev_time,
    input  wire logic [30:0] prior_height,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      next_bits,
    output logic             rule_applied
);
    import adt_pkg::*;

    logic [30:0]      act_reg;
    logic [31:0]      ref_bits_reg, ref_time_reg, half_life_reg, limit_bits_reg;
    logic [13:0]      spacing_reg;
    logic [TGT_W-1:0] anchor_target_reg, limit_reg;

    logic               adv;
    logic               applied;
    logic [30:0]        hdiff;
    logic [45:0]        drift;
    logic signed [32:0] tdiff;
    logic signed [47:0] n0;
    logic [47:0]        mag;
    div_t               div_reg;
    exp_t               exp_w;
    fac_t               fac_w;
    side_t              res_w;
    logic               out_valid_reg;
    logic [31:0]        next_bits_reg;
    logic               rule_applied_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg        <= 31'd0;
            ref_bits_reg   <= 32'd486604799;
            ref_time_reg   <= 32'd0;
            spacing_reg    <= 14'd600;
            half_life_reg  <= 32'd172800;
            limit_bits_reg <= 32'd486604799;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACT_HEIGHT: act_reg        <= cfg_data[30:0];
                REG_REF_BITS:   ref_bits_reg   <= cfg_data;
                REG_REF_TIME:   ref_time_reg   <= cfg_data;
                REG_SPACING:    spacing_reg    <= cfg_data[13:0];
                REG_HALF_LIFE:  half_life_reg  <= cfg_data;
                REG_LIMIT_BITS: limit_bits_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        anchor_target_reg <= decode_compact(ref_bits_reg);
        limit_reg         <= decode_compact(limit_bits_reg);
    end

    assign applied = prior_height >= act_reg;
    assign hdiff   = prior_height - act_reg;
    assign tdiff   = $signed({1'b0, prev_time}) - $signed({1'b0, ref_time_reg});
    assign drift   = {32'b0, spacing_reg} * ({15'b0, hdiff} + 46'd1);
    assign n0      = $signed({{15{tdiff[32]}}, tdiff}) - $signed({2'b0, drift});
    assign mag     = n0[47] ? 48'(-n0) : 48'(n0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg.side.valid <= 1'b0;
        end
        else if (adv)
        begin
            div_reg.side.valid   <= in_valid;
            div_reg.side.applied <= applied;
            div_reg.side.bits    <= prev_bits;
            div_reg.neg          <= n0[47];
            div_reg.hl           <= (half_life_reg == 32'd0) ? 32'd1 : half_life_reg;
            div_reg.rem          <= 32'd0;
            div_reg.num          <= {mag[45:0], 16'b0};
        end
    end

    adt_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .din   (div_reg),
        .dout  (exp_w)
    );

    adt_poly u_poly (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .din   (exp_w),
        .dout  (fac_w)
    );

    adt_target u_tgt (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .din           (fac_w),
        .anchor_target (anchor_target_reg),
        .limit         (limit_reg),
        .dout          (res_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg    <= res_w.valid;
            next_bits_reg    <= res_w.bits;
            rule_applied_reg <= res_w.applied;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_bits    = next_bits_reg;
    assign rule_applied = rule_applied_reg;

endmodule
`default_nettype wire
